>>> rtl/core/sbq_pkg.sv
// ----------------------------------------------------------------------------
// sbq_pkg
// Shared types, constants and helpers for the stacked biquad filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sbq_pkg;

	// Delay line format is Q9.31 in 40 bits.
	localparam int DLY_W = 40;
	// Floored product signal*coef, before the 40-bit saturation.
	localparam int PROD_W = 42;
	// Width of the section adders, wide enough for +-2p - m + s2.
	localparam int SUM_W = 45;
	// The 40-bit operand is split into a signed high part and a 16-bit low part.
	localparam int SPLIT = 16;
	localparam int MUL_OP_W = DLY_W - SPLIT + 1;

	localparam int COEF_IDX_W = 5;
	localparam int COEF_VALUE_W = 32;
	localparam int DLY_IDX_W = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic OP_FILTER = 1'b0;
	localparam logic OP_COEF = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_HIGHPASS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS = 2'd1;

	// Access request from the sequencer to the state store.
	typedef struct packed {
		logic coef_we;
		logic [COEF_IDX_W-1:0] coef_wa;
		logic [COEF_IDX_W-1:0] coef_ra;
		logic dly_we;
		logic [DLY_IDX_W-1:0] dly_wa;
		logic [DLY_IDX_W-1:0] dly_ra;
		logic dly_clr;
	} store_req_t;

	// Saturate a section sum to the signed 40-bit delay range.
	function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [SUM_W-1:0] v);
		logic signed [DLY_W-1:0] r;
		if (v[SUM_W-1:DLY_W-1] != {(SUM_W-DLY_W+1){v[SUM_W-1]}}) begin
			r = v[SUM_W-1] ? {1'b1, {(DLY_W-1){1'b0}}} : {1'b0, {(DLY_W-1){1'b1}}};
		end else begin
			r = v[DLY_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/sbq_ram.sv
// ----------------------------------------------------------------------------
// sbq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sbq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/sbq_mulc.sv
// ----------------------------------------------------------------------------
// sbq_mulc
// Shared coefficient multiplier: floor(a * c / 2^(COEF_BITS-2)) for a 40-bit
// signal, computed as two partial products on one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module sbq_mulc import sbq_pkg::*; #(
	parameter int COEF_BITS = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic signed [DLY_W-1:0]     a,
	input  wire logic signed [COEF_BITS-1:0] c,
	output logic                             done,
	output logic signed [PROD_W-1:0]         res
);

	localparam int M_W = MUL_OP_W + COEF_BITS;
	localparam int F_W = M_W + SPLIT;
	localparam int FRAC_SHIFT = COEF_BITS - 2;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_HI   = 4'b0010,
		PH_LO   = 4'b0100,
		PH_SUM  = 4'b1000
	} phase_t;

	phase_t phase_q;
	logic done_q;
	logic signed [DLY_W-1:0] a_q;
	logic signed [COEF_BITS-1:0] c_q;
	logic signed [M_W-1:0] ph_q;
	logic signed [M_W-1:0] pl_q;
	logic signed [PROD_W-1:0] res_q;

	logic signed [MUL_OP_W-1:0] m_a;
	logic signed [M_W-1:0] m_p;
	logic signed [F_W-1:0] full;
	logic signed [F_W-1:0] shifted;

	// High part is signed, low part is a plain 16-bit magnitude.
	always_comb begin
		case (phase_q)
			PH_HI:   m_a = MUL_OP_W'(signed'(a_q[DLY_W-1:SPLIT]));
			default: m_a = MUL_OP_W'(a_q[SPLIT-1:0]);
		endcase
	end

	assign m_p = m_a * c_q;
	assign full = {ph_q, {SPLIT{1'b0}}} + F_W'(pl_q);
	assign shifted = full >>> FRAC_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_HI;
					end
				end
				PH_HI:  phase_q <= PH_LO;
				PH_LO:  phase_q <= PH_SUM;
				PH_SUM: begin
					phase_q <= PH_IDLE;
					done_q <= 1'b1;
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && phase_q == PH_IDLE) begin
			a_q <= a;
			c_q <= c;
		end
		if (phase_q == PH_HI) begin
			ph_q <= m_p;
		end
		if (phase_q == PH_LO) begin
			pl_q <= m_p;
		end
		if (phase_q == PH_SUM) begin
			res_q <= shifted[PROD_W-1:0];
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

`default_nettype wire

>>> rtl/core/sbq_store.sv
// ----------------------------------------------------------------------------
// sbq_store
// Coefficient and section delay memories with per-entry valid bits, so that
// entries read as zero until first written after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sbq_store import sbq_pkg::*; #(
	parameter int COEF_BITS = 32,
	parameter int SECTIONS = 3
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire store_req_t           req,
	input  wire logic [COEF_BITS-1:0] coef_wdata,
	input  wire logic [DLY_W-1:0]     dly_wdata,
	output logic      [COEF_BITS-1:0] coef_rdata,
	output logic      [DLY_W-1:0]     dly_rdata
);

	localparam int NCOEF = 6 * SECTIONS;
	localparam int NDLY = 4 * SECTIONS;
	localparam int CA_W = $clog2(NCOEF);
	localparam int DA_W = $clog2(NDLY);

	logic [CA_W-1:0] ca_wa;
	logic [CA_W-1:0] ca_ra;
	logic [DA_W-1:0] da_wa;
	logic [DA_W-1:0] da_ra;

	logic [NCOEF-1:0] coef_vld_q;
	logic [NDLY-1:0] dly_vld_q;
	logic coef_rvld_q;
	logic dly_rvld_q;

	logic [COEF_BITS-1:0] coef_ram_q;
	logic [DLY_W-1:0] dly_ram_q;

	assign ca_wa = req.coef_wa[CA_W-1:0];
	assign ca_ra = req.coef_ra[CA_W-1:0];
	assign da_wa = req.dly_wa[DA_W-1:0];
	assign da_ra = req.dly_ra[DA_W-1:0];

	// Valid bits are read with the same timing as the registered RAM data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
			dly_vld_q <= '0;
			coef_rvld_q <= 1'b0;
			dly_rvld_q <= 1'b0;
		end else begin
			coef_rvld_q <= coef_vld_q[ca_ra];
			dly_rvld_q <= dly_vld_q[da_ra];
			if (req.coef_we) begin
				coef_vld_q[ca_wa] <= 1'b1;
			end
			if (req.dly_we) begin
				dly_vld_q[da_wa] <= 1'b1;
			end
			if (req.dly_clr) begin
				dly_vld_q[0] <= 1'b0;
				dly_vld_q[1] <= 1'b0;
			end
		end
	end

	sbq_ram #(
		.WIDTH(COEF_BITS),
		.DEPTH(NCOEF)
	) u_coef_ram (
		.clk  (clk),
		.we   (req.coef_we),
		.waddr(ca_wa),
		.wdata(coef_wdata),
		.raddr(ca_ra),
		.rdata(coef_ram_q)
	);

	sbq_ram #(
		.WIDTH(DLY_W),
		.DEPTH(NDLY)
	) u_dly_ram (
		.clk  (clk),
		.we   (req.dly_we),
		.waddr(da_wa),
		.wdata(dly_wdata),
		.raddr(da_ra),
		.rdata(dly_ram_q)
	);

	assign coef_rdata = coef_rvld_q ? coef_ram_q : '0;
	assign dly_rdata = dly_rvld_q ? dly_ram_q : '0;

endmodule

`default_nettype wire

>>> rtl/core/stacked_biquad_highpass_lowpass.sv
// ----------------------------------------------------------------------------
// stacked_biquad_highpass_lowpass
// Mono audio filter: a highpass stack followed by a lowpass stack, each made
// of SECTIONS transposed direct form II biquads sharing one multiplier.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_ready      opcode, sample_in, coef_index, coef_value
// result    out        result_valid / result_ready  sample_out, clipped
// cfg       in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// A coefficient write is complete once it is accepted. A sample runs through 0,
// SECTIONS or 2*SECTIONS sections, as the mode bits select. Each section reads
// its memories in the states RD0 to RD3, then waits in MP, MB1 and MB2 for the
// three products on the shared two-pass multiplier. Reset clears the control
// registers and the memory valid bits at once; no clearing pass is needed. A new
// item transfer is taken while the previous result still waits; only the next
// finished sample stalls until the result slot is free.
//
`default_nettype none

module stacked_biquad_highpass_lowpass import sbq_pkg::*; #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS = 32,
	parameter int SECTIONS = 3
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Item channel.
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic                          opcode,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
	input  wire logic [COEF_IDX_W-1:0]         coef_index,
	input  wire logic signed [COEF_VALUE_W-1:0] coef_value,
	// Result channel.
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic signed [SAMPLE_BITS-1:0]      sample_out,
	output logic                               clipped,
	// Configuration channel.
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic                          cfg_data
);

	localparam int NCOEF = 6 * SECTIONS;
	localparam int NDLY = 4 * SECTIONS;
	localparam int CA_W = $clog2(NCOEF);
	localparam int DA_W = $clog2(NDLY);
	localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	// Shift between the sample format and the Q9.31 delay format.
	localparam int IO_SHIFT = 32 - SAMPLE_BITS;

	localparam logic [COEF_IDX_W-1:0] NCOEF_IDX = COEF_IDX_W'(NCOEF);
	localparam logic [CA_W-1:0] LP_CBASE = CA_W'(3 * SECTIONS);
	localparam logic [DA_W-1:0] LP_DBASE = DA_W'(2 * SECTIONS);
	localparam logic [CA_W-1:0] CI_STEP = CA_W'(3);
	localparam logic [DA_W-1:0] DI_STEP = DA_W'(2);
	localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTIONS - 1);

	// Per-section sequence: the read states RD0 to RD3, then one wait state per product.
	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_RD0  = 9'b000000010,
		ST_RD1  = 9'b000000100,
		ST_RD2  = 9'b000001000,
		ST_RD3  = 9'b000010000,
		ST_MP   = 9'b000100000,
		ST_MB1  = 9'b001000000,
		ST_MB2  = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;

	state_t state_q;
	logic hp_on_q;
	logic lp_on_q;
	logic filt_q;
	logic [SEC_W-1:0] sec_q;
	logic [CA_W-1:0] ci_q;
	logic [DA_W-1:0] di_q;
	logic result_valid_q;

	// Datapath registers.
	logic signed [DLY_W-1:0] x_q;
	logic signed [DLY_W-1:0] s1_q;
	logic signed [DLY_W-1:0] s2_q;
	logic signed [DLY_W-1:0] y_q;
	logic signed [PROD_W-1:0] p_q;
	logic signed [COEF_BITS-1:0] b1_q;
	logic signed [COEF_BITS-1:0] b2_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic clipped_q;

	logic item_xfer;
	logic sample_xfer;
	logic result_free;

	store_req_t store_req;
	logic signed [COEF_BITS-1:0] coef_rdata;
	logic signed [DLY_W-1:0] dly_rdata;
	logic signed [DLY_W-1:0] dly_wdata;

	logic mul_start;
	logic signed [DLY_W-1:0] mul_a;
	logic signed [COEF_BITS-1:0] mul_c;
	logic mul_done;
	logic signed [PROD_W-1:0] mul_res;

	logic signed [DLY_W-1:0] x_in;
	logic signed [SUM_W-1:0] p2;
	logic signed [SUM_W-1:0] sum_sel;
	logic signed [DLY_W-1:0] sat_out;
	logic signed [DLY_W-1:0] out_shifted;
	logic out_clip;
	logic signed [SAMPLE_BITS-1:0] out_sat;

	logic [CA_W-1:0] coef_ra;
	logic [DA_W-1:0] dly_ra;
	logic [DA_W-1:0] dly_wa;

	assign item_ready = (state_q == ST_IDLE);
	assign item_xfer = item_valid && item_ready;
	assign sample_xfer = item_xfer && (opcode == OP_FILTER);
	assign result_free = !result_valid_q || result_ready;
	assign cfg_ready = 1'b1;

	// The sample enters the Q9.31 domain.
	assign x_in = {{(DLY_W-SAMPLE_BITS){sample_in[SAMPLE_BITS-1]}}, sample_in} <<< IO_SHIFT;

	// One saturating adder serves the three section updates:
	//   y  = p + s1
	//   s1 = +-2p - y*b1 + s2   (minus sign in highpass sections)
	//   s2 = p - y*b2
	assign p2 = SUM_W'(p_q) <<< 1;

	always_comb begin
		case (state_q)
			ST_MP:   sum_sel = SUM_W'(mul_res) + SUM_W'(s1_q);
			ST_MB1:  sum_sel = (filt_q ? p2 : -p2) - SUM_W'(mul_res) + SUM_W'(s2_q);
			default: sum_sel = SUM_W'(p_q) - SUM_W'(mul_res);
		endcase
	end

	assign sat_out = sat_dly(sum_sel);
	assign dly_wdata = sat_out;

	// Multiplier operands: x*a0 starts while b1 and b2 are still being read;
	// y*b1 starts as soon as y is known, y*b2 right after.
	always_comb begin
		mul_start = 1'b0;
		mul_a = y_q;
		mul_c = b2_q;
		case (state_q)
			ST_RD1: begin
				mul_start = 1'b1;
				mul_a = x_q;
				mul_c = coef_rdata;
			end
			ST_MP: begin
				mul_start = mul_done;
				mul_a = sat_out;
				mul_c = b1_q;
			end
			ST_MB1: begin
				mul_start = mul_done;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	// Memory addresses: terms a0, b1, b2 follow the coefficient base, and the
	// two delays of a section follow the delay base.
	always_comb begin
		case (state_q)
			ST_RD1:  coef_ra = ci_q + CA_W'(1);
			ST_RD2:  coef_ra = ci_q + CA_W'(2);
			default: coef_ra = ci_q;
		endcase
	end

	assign dly_ra = (state_q == ST_RD1) ? di_q + DA_W'(1) : di_q;
	assign dly_wa = (state_q == ST_MB2) ? di_q + DA_W'(1) : di_q;

	always_comb begin
		store_req.coef_we = item_xfer && (opcode == OP_COEF) && (coef_index < NCOEF_IDX);
		store_req.coef_wa = coef_index;
		store_req.coef_ra = COEF_IDX_W'(coef_ra);
		store_req.dly_we = mul_done && (state_q == ST_MB1 || state_q == ST_MB2);
		store_req.dly_wa = DLY_IDX_W'(dly_wa);
		store_req.dly_ra = DLY_IDX_W'(dly_ra);
		// With the highpass off, its first section is held at rest.
		store_req.dly_clr = sample_xfer && !hp_on_q;
	end

	sbq_store #(
		.COEF_BITS(COEF_BITS),
		.SECTIONS (SECTIONS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (store_req),
		.coef_wdata(coef_value[COEF_BITS-1:0]),
		.dly_wdata (dly_wdata),
		.coef_rdata(coef_rdata),
		.dly_rdata (dly_rdata)
	);

	sbq_mulc #(
		.COEF_BITS(COEF_BITS)
	) u_mulc (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.c     (mul_c),
		.done  (mul_done),
		.res   (mul_res)
	);

	// Output: floor back to the sample format and saturate.
	assign out_shifted = x_q >>> IO_SHIFT;
	assign out_clip = out_shifted[DLY_W-1:SAMPLE_BITS-1] !=
		{(DLY_W-SAMPLE_BITS+1){out_shifted[DLY_W-1]}};

	always_comb begin
		if (!out_clip) begin
			out_sat = out_shifted[SAMPLE_BITS-1:0];
		end else if (out_shifted[DLY_W-1]) begin
			out_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			out_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hp_on_q <= 1'b0;
			lp_on_q <= 1'b0;
			filt_q <= 1'b0;
			sec_q <= '0;
			ci_q <= '0;
			di_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_HIGHPASS: hp_on_q <= cfg_data;
					CFG_LOWPASS:  lp_on_q <= cfg_data;
					default: ;
				endcase
			end

			if (state_q == ST_DONE && result_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (sample_xfer) begin
						sec_q <= '0;
						if (hp_on_q) begin
							filt_q <= 1'b0;
							ci_q <= '0;
							di_q <= '0;
							state_q <= ST_RD0;
						end else if (lp_on_q) begin
							filt_q <= 1'b1;
							ci_q <= LP_CBASE;
							di_q <= LP_DBASE;
							state_q <= ST_RD0;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: state_q <= ST_RD3;
				ST_RD3: state_q <= ST_MP;
				ST_MP: begin
					if (mul_done) begin
						state_q <= ST_MB1;
					end
				end
				ST_MB1: begin
					if (mul_done) begin
						state_q <= ST_MB2;
					end
				end
				ST_MB2: begin
					if (mul_done) begin
						// The lowpass bases follow directly after the highpass ones.
						if (sec_q != SEC_LAST) begin
							sec_q <= sec_q + SEC_W'(1);
							ci_q <= ci_q + CI_STEP;
							di_q <= di_q + DI_STEP;
							state_q <= ST_RD0;
						end else if (!filt_q && lp_on_q) begin
							filt_q <= 1'b1;
							sec_q <= '0;
							ci_q <= ci_q + CI_STEP;
							di_q <= di_q + DI_STEP;
							state_q <= ST_RD0;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (result_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (sample_xfer) begin
			x_q <= x_in;
		end
		if (state_q == ST_RD1) begin
			s1_q <= dly_rdata;
		end
		if (state_q == ST_RD2) begin
			b1_q <= coef_rdata;
			s2_q <= dly_rdata;
		end
		if (state_q == ST_RD3) begin
			b2_q <= coef_rdata;
		end
		if (state_q == ST_MP && mul_done) begin
			p_q <= mul_res;
			y_q <= sat_out;
		end
		if (state_q == ST_MB2 && mul_done) begin
			x_q <= y_q;
		end
		if (state_q == ST_DONE && result_free) begin
			sample_out_q <= out_sat;
			clipped_q <= out_clip;
		end
	end

	assign result_valid = result_valid_q;
	assign sample_out = sample_out_q;
	assign clipped = clipped_q;

`ifndef NO_ASSERTIONS
	// A product may only complete while the sequencer waits for one.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_MP || state_q == ST_MB1 || state_q == ST_MB2))
		else $error("multiplier finished outside a wait state");

	// An accepted sample always starts work.
	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		sample_xfer |=> (state_q != ST_IDLE))
		else $error("sample transfer left the sequencer idle");

	// Delay writes stay inside the delay memory.
	a_dly_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		store_req.dly_we |-> (int'(store_req.dly_wa) < NDLY))
		else $error("delay write address out of range");

	// The section counter never runs past the last section.
	a_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (int'(sec_q) < SECTIONS))
		else $error("section counter out of range");
`endif

endmodule

`default_nettype wire

>>> test/stacked_biquad_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stacked_biquad_checker
// Watches the item, result and configuration channels of the stacked biquad
// filter. It keeps its own copy of the coefficients, delays and mode bits,
// works out each filtered sample and compares it with what the block returns.
// ----------------------------------------------------------------------------

module stacked_biquad_checker import sbq_pkg::*; #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS = 32,
	parameter int SECTIONS = 3
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  logic                           item_ready,
	input  logic                           opcode,
	input  logic signed [SAMPLE_BITS-1:0]  sample_in,
	input  logic [COEF_IDX_W-1:0]          coef_index,
	input  logic signed [COEF_VALUE_W-1:0] coef_value,
	input  logic                           result_valid,
	input  logic                           result_ready,
	input  logic signed [SAMPLE_BITS-1:0]  sample_out,
	input  logic                           clipped,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic                           cfg_data,
	output int                             outstanding,
	output int                             failures
);

	localparam int NUM_COEFS = 6 * SECTIONS;
	localparam int NUM_DELAYS = 4 * SECTIONS;
	// Samples enter the Q9.31 delay domain by this shift.
	localparam int SAMPLE_SHIFT = 31 - (SAMPLE_BITS - 1);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic clip;
	} filtered_t;

	longint coefs [NUM_COEFS];
	longint delays [NUM_DELAYS];
	logic highpass_en;
	logic lowpass_en;
	filtered_t expected_samples [$];

	function automatic longint clamp_bits(input longint v, input int w, output logic hit);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		hit = 1'b0;
		if (v > hi) begin
			hit = 1'b1;
			return hi;
		end
		if (v < lo) begin
			hit = 1'b1;
			return lo;
		end
		return v;
	endfunction

	// Signal times coefficient, floored back to Q9.31.
	function automatic longint coef_product(input longint sig, input longint coef);
		logic signed [95:0] ws;
		logic signed [95:0] wc;
		logic signed [95:0] wide;
		ws = sig;
		wc = coef;
		wide = ws * wc;
		return longint'(wide >>> (COEF_BITS - 2));
	endfunction

	// One stack of transposed direct form II sections; filt 0 is the highpass.
	function automatic longint run_sections(input longint x, input int filt);
		longint p;
		longint y;
		longint dbl;
		logic hit;
		int ci;
		int di;
		for (int s = 0; s < SECTIONS; s++) begin
			ci = filt * 3 * SECTIONS + s * 3;
			di = (filt * SECTIONS + s) * 2;
			p = coef_product(x, coefs[ci]);
			y = clamp_bits(p + delays[di], DLY_W, hit);
			dbl = (filt == 0) ? -2 * p : 2 * p;
			delays[di] = clamp_bits(dbl - coef_product(y, coefs[ci + 1]) + delays[di + 1],
				DLY_W, hit);
			delays[di + 1] = clamp_bits(p - coef_product(y, coefs[ci + 2]), DLY_W, hit);
			x = y;
		end
		return x;
	endfunction

	function automatic filtered_t filter_sample(input logic signed [SAMPLE_BITS-1:0] s);
		longint x;
		filtered_t r;
		logic hit;
		x = s;
		x = x <<< SAMPLE_SHIFT;
		if (highpass_en) begin
			x = run_sections(x, 0);
		end else begin
			// A bypassed highpass only flushes its first section.
			delays[0] = 0;
			delays[1] = 0;
		end
		if (lowpass_en) begin
			x = run_sections(x, 1);
		end
		x = clamp_bits(x >>> SAMPLE_SHIFT, SAMPLE_BITS, hit);
		r.sample = x[SAMPLE_BITS-1:0];
		r.clip = hit;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		filtered_t want;
		longint cval;
		if (!arst_n) begin
			foreach (coefs[i]) coefs[i] = 0;
			foreach (delays[i]) delays[i] = 0;
			highpass_en = 1'b0;
			lowpass_en = 1'b0;
			expected_samples.delete();
			failures = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_HIGHPASS: highpass_en = cfg_data;
					CFG_LOWPASS: lowpass_en = cfg_data;
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (expected_samples.size() == 0) begin
					$error("result transfer with no expected sample waiting");
					failures++;
				end else begin
					want = expected_samples.pop_front();
					if (sample_out !== want.sample) begin
						$error("sample_out: expected %0d, actual %0d", want.sample, sample_out);
						failures++;
					end
					if (clipped !== want.clip) begin
						$error("clipped: expected %0d, actual %0d", want.clip, clipped);
						failures++;
					end
				end
			end
			if (item_valid && item_ready) begin
				if (opcode == OP_COEF) begin
					if (coef_index < NUM_COEFS) begin
						cval = $signed(coef_value[COEF_BITS-1:0]);
						coefs[coef_index] = cval;
					end
				end else begin
					expected_samples.push_back(filter_sample(sample_in));
				end
			end
			outstanding <= expected_samples.size();
		end
	end

endmodule

>>> test/tb_stacked_biquad_highpass_lowpass.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stacked_biquad_highpass_lowpass
// Drives the stacked highpass/lowpass filter with directed corner cases and
// then with phases of Butterworth or raw random coefficients followed by
// random samples, under every mode setting and with random gaps on both
// channels. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_stacked_biquad_highpass_lowpass;
	import sbq_pkg::*;

	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS = 32;
	localparam int SECTIONS = 3;
	localparam int NUM_COEFS = 6 * SECTIONS;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 82;
	// Settle for longer than a full sample through both stacks takes.
	localparam int SETTLE_CYCLES = 120;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [COEF_VALUE_W-1:0] COEF_MAX = {1'b0, {(COEF_VALUE_W-1){1'b1}}};
	localparam logic signed [COEF_VALUE_W-1:0] COEF_MIN = {1'b1, {(COEF_VALUE_W-1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	logic opcode;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic [COEF_IDX_W-1:0] coef_index;
	logic signed [COEF_VALUE_W-1:0] coef_value;
	logic result_valid;
	logic result_ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic clipped;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic cfg_data;

	int outstanding;
	int failures;
	// When set, neither the sender nor the receiver inserts any gaps.
	logic quiet = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	stacked_biquad_highpass_lowpass #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_BITS(COEF_BITS),
		.SECTIONS(SECTIONS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.opcode(opcode),
		.sample_in(sample_in),
		.coef_index(coef_index),
		.coef_value(coef_value),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.sample_out(sample_out),
		.clipped(clipped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	stacked_biquad_checker #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_BITS(COEF_BITS),
		.SECTIONS(SECTIONS)
	) checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.opcode(opcode),
		.sample_in(sample_in),
		.coef_index(coef_index),
		.coef_value(coef_value),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.sample_out(sample_out),
		.clipped(clipped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.outstanding(outstanding),
		.failures(failures)
	);

	// The result side stalls at random about 23 percent of the time, except while
	// the quiet stretch is running.
	always @(posedge clk) begin
		result_ready <= quiet || ($urandom_range(99) >= 23);
	end

	// Present one item and hold it until the transfer happens. A gap, when one
	// is taken, comes before valid rises, so valid never drops while an item
	// is waiting and is never lowered and raised in the same time step.
	task automatic send_item(input logic op, input logic signed [SAMPLE_BITS-1:0] s,
		input logic [COEF_IDX_W-1:0] idx, input logic signed [COEF_VALUE_W-1:0] val);
		if (!quiet) begin
			while ($urandom_range(99) < 23) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_valid <= 1'b1;
		opcode <= op;
		sample_in <= s;
		coef_index <= idx;
		coef_value <= val;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	// Fields that the operation does not use still carry random bits.
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
		send_item(OP_FILTER, s, COEF_IDX_W'($urandom), $urandom);
	endtask

	task automatic send_coef(input logic [COEF_IDX_W-1:0] idx,
		input logic signed [COEF_VALUE_W-1:0] val);
		send_item(OP_COEF, SAMPLE_BITS'($urandom), idx, val);
	endtask

	// Stop sending, let every expected result come back, then give the block
	// time to finish any trailing coefficient write before going on.
	task automatic drain(input int extra_cycles);
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (extra_cycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Mode changes are made only with the block idle.
	task automatic set_mode(input logic hp, input logic lp);
		drain(SETTLE_CYCLES);
		write_reg(CFG_HIGHPASS, hp);
		write_reg(CFG_LOWPASS, lp);
		cfg_valid <= 1'b0;
	endtask

	// Loads a sixth-order Butterworth design into both stacks. The three
	// sections use the quality factors of a sixth-order Butterworth response;
	// k is the prewarped cutoff, tan(pi*fc/fs). The block derives a1 and a2.
	task automatic load_butterworth(input real k_hp, input real k_lp);
		real k;
		real q;
		real norm;
		real a0;
		real b1;
		real b2;
		for (int f = 0; f < 2; f++) begin
			for (int s = 0; s < SECTIONS; s++) begin
				case (s % 3)
					0: q = 0.51763809;
					1: q = 0.70710678;
					default: q = 1.93185165;
				endcase
				k = (f == 0) ? k_hp : k_lp;
				norm = 1.0 / (1.0 + k / q + k * k);
				a0 = (f == 0) ? norm : k * k * norm;
				b1 = 2.0 * (k * k - 1.0) * norm;
				b2 = (1.0 - k / q + k * k) * norm;
				send_coef(COEF_IDX_W'(f * 3 * SECTIONS + s * 3),
					int'(a0 * 1073741824.0));
				send_coef(COEF_IDX_W'(f * 3 * SECTIONS + s * 3 + 1),
					int'(b1 * 1073741824.0));
				send_coef(COEF_IDX_W'(f * 3 * SECTIONS + s * 3 + 2),
					int'(b2 * 1073741824.0));
			end
		end
	endtask

	initial begin
		logic signed [COEF_VALUE_W-1:0] raw;
		int pick;

		arst_n <= 1'b0;
		item_valid <= 1'b0;
		opcode <= OP_FILTER;
		sample_in <= '0;
		coef_index <= '0;
		coef_value <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_HIGHPASS;
		cfg_data <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Both stacks are off after reset, so samples pass straight through,
		// extremes included, and never clip. Writes beyond the last
		// coefficient must be dropped.
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample('0);
		send_sample(SAMPLE_BITS'(-1));
		send_coef(5'd31, COEF_MIN);
		send_coef(5'd18, COEF_MAX);
		send_coef(5'd17, COEF_MIN);
		send_sample(SAMPLE_BITS'(1));

		// Lowpass alone with the largest gain in each section drives the
		// output far past full scale, so both saturation directions show up.
		set_mode(1'b0, 1'b1);
		send_coef(5'd9, COEF_MAX);
		send_coef(5'd12, COEF_MAX);
		send_coef(5'd15, COEF_MAX);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_BITS'(1));
		send_sample(SAMPLE_BITS'(-1));

		// Highpass alone with the most negative gain: the doubled a1 term
		// and the delay saturation are hit at once.
		set_mode(1'b1, 1'b0);
		send_coef(5'd0, COEF_MIN);
		send_coef(5'd3, COEF_MIN);
		send_coef(5'd6, COEF_MIN);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample('0);

		// Random phases walk through every mode setting. Most load a proper
		// Butterworth design so the filters run in their useful range; every
		// third one loads raw random words to stress saturation. One phase
		// runs with no gaps on either side.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_mode(~ph[0], ~ph[1]);
			quiet = (ph == 4);
			if (ph % 3 == 2) begin
				for (int i = 0; i < NUM_COEFS; i++) begin
					raw = $urandom;
					send_coef(COEF_IDX_W'(i), raw >>> $urandom_range(0, 8));
				end
			end else begin
				load_butterworth($urandom_range(1, 600) / 200.0,
					$urandom_range(1, 600) / 200.0);
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick = $urandom_range(99);
				if (pick < 5) begin
					// Stray write, mostly to an index past the store.
					send_coef(COEF_IDX_W'($urandom_range(0, 1) ? $urandom_range(18, 31) :
						$urandom_range(0, 31)), $urandom);
				end else if (pick < 60) begin
					send_sample(SAMPLE_BITS'($urandom));
				end else if (pick < 88) begin
					send_sample(SAMPLE_BITS'($urandom_range(0, 8191) - 4096));
				end else begin
					send_sample($urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN);
				end
			end
			quiet = 1'b0;
		end

		drain(200);
		if (failures == 0 && outstanding == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Well over ten times the slowest legal run.
	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
